// ===== src/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the scan smoothness scorer.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int SIDE_SPAN          = 5;
    localparam int COORD_BITS         = 16;
    localparam int WIN                = 2 * SIDE_SPAN + 1;
    localparam int WIN_BITS           = $clog2(WIN + 1);
    localparam int SLOT_BITS          = $clog2(WIN);

    localparam logic CFG_DISTANCE_LIMIT = 1'b0;
    localparam logic CFG_MIN_NEIGHBORS  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // one center job handed from front to back
    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [WIN_BITS-1:0]  fill;
        logic [15:0]          index;
        logic                 last;
    } job_t;

    // back to front: window entries still referenced
    typedef struct packed {
        logic busy;
    } back_status_t;

endpackage

// ===== src/sss_sqrt.sv =====
// ----------------------------------------------------------------------------
// sss_sqrt
// Bit-serial integer square root of a 64-bit value, two bits per cycle.
// ----------------------------------------------------------------------------
module sss_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        run_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;
    assign root  = res_reg[31:0];

    // one digit pair per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                rem_reg <= radicand;
                res_reg <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== src/sss_div.sv =====
// ----------------------------------------------------------------------------
// sss_div
// Restoring divider: floor(num * 65536 / den), saturated to 16 bits.
// ----------------------------------------------------------------------------
module sss_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [15:0] quot
);
    logic [32:0] rem_reg;
    logic [16:0] q_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic [33:0] shifted;
    logic        ge;

    assign shifted = {rem_reg, 1'b0};
    assign ge      = shifted >= {2'b00, den};
    assign quot    = q_reg[16] ? 16'hFFFF : q_reg[15:0];

    // one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                // integer part is at most 1 since num <= den
                rem_reg <= (num >= den) ? {1'b0, num - den} : {1'b0, num};
                q_reg   <= {16'd0, (num >= den)};
                cnt_reg <= 5'd16;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                rem_reg <= ge ? 33'(shifted - {2'b00, den}) : shifted[32:0];
                q_reg   <= {q_reg[15:0], ge};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== src/sss_front.sv =====
// ----------------------------------------------------------------------------
// sss_front
// Point window, index tracking and center job queue.
// ----------------------------------------------------------------------------
module sss_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sss_pkg::coord_t        pos_x,
    input  sss_pkg::coord_t        pos_y,
    input  logic                   end_of_scan,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [sss_pkg::SLOT_BITS-1:0] rd_slot,
    output sss_pkg::coord_t        rd_x,
    output sss_pkg::coord_t        rd_y,
    output logic                   job_valid,
    output sss_pkg::job_t          job,
    input  logic                   job_take,
    input  sss_pkg::back_status_t  status
);
    import sss_pkg::*;

    coord_t              win_x_reg [WIN];
    coord_t              win_y_reg [WIN];
    logic [WIN_BITS-1:0] fill_reg;
    logic [15:0]         idx_reg;
    job_t                q_reg [WIN];
    logic [WIN_BITS-1:0] qcnt_reg;
    logic [WIN_BITS-1:0] fill_next;
    logic                accept;

    // take a point only when no job or scoring still uses the window
    assign in_ready  = (qcnt_reg == '0) && !status.busy;
    assign accept    = in_valid && in_ready;
    assign job_valid = qcnt_reg != '0;
    assign job       = q_reg[0];
    assign rd_x      = win_x_reg[rd_slot];
    assign rd_y      = win_y_reg[rd_slot];
    assign fill_next = (fill_reg < WIN_BITS'(WIN)) ? fill_reg + 1'b1 : fill_reg;

    // shift window and queue up center jobs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            idx_reg  <= '0;
            qcnt_reg <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < WIN - 1; i++)
            begin
                win_x_reg[i] <= win_x_reg[i+1];
                win_y_reg[i] <= win_y_reg[i+1];
            end
            win_x_reg[WIN-1] <= pos_x;
            win_y_reg[WIN-1] <= pos_y;
            if (!end_of_scan)
            begin
                fill_reg <= fill_next;
                idx_reg  <= idx_reg + 16'd1;
                if (fill_next >= WIN_BITS'(SIDE_SPAN + 1))
                begin
                    q_reg[0].slot  <= SLOT_BITS'(WIN - 1 - SIDE_SPAN);
                    q_reg[0].fill  <= fill_next;
                    q_reg[0].index <= idx_reg - 16'(SIDE_SPAN);
                    q_reg[0].last  <= 1'b0;
                    qcnt_reg       <= WIN_BITS'(1);
                end
            end
            else
            begin
                // flush: one job per pending center, oldest first
                logic [WIN_BITS-1:0] first;
                logic [WIN_BITS-1:0] n;
                first = WIN_BITS'(WIN - 1 - SIDE_SPAN);
                if (first < WIN_BITS'(WIN) - fill_next)
                    first = WIN_BITS'(WIN) - fill_next;
                n = WIN_BITS'(WIN) - first;
                for (int k = 0; k < WIN; k++)
                begin
                    q_reg[k].slot  <= SLOT_BITS'(first + WIN_BITS'(k));
                    q_reg[k].fill  <= fill_next;
                    q_reg[k].index <= idx_reg - 16'(n) + 16'(k + 1);
                    q_reg[k].last  <= (WIN_BITS'(k) == n - 1'b1);
                end
                qcnt_reg <= n;
                fill_reg <= '0;
                idx_reg  <= '0;
            end
        end
        else if (job_take)
        begin
            for (int k = 0; k < WIN - 1; k++)
                q_reg[k] <= q_reg[k+1];
            qcnt_reg <= qcnt_reg - 1'b1;
        end
    end
endmodule

// ===== src/sss_back.sv =====
// ----------------------------------------------------------------------------
// sss_back
// Scores one center: neighbor sweep, scatter matrix, sqrt and ratio.
// ----------------------------------------------------------------------------
module sss_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [15:0]            distance_limit,
    input  logic [5:0]             min_neighbors,
    input  logic                   job_valid,
    input  sss_pkg::job_t          job,
    output logic                   job_take,
    output logic [sss_pkg::SLOT_BITS-1:0] rd_slot,
    input  sss_pkg::coord_t        rd_x,
    input  sss_pkg::coord_t        rd_y,
    output sss_pkg::back_status_t  status,
    output sss_pkg::coord_t        center_x,
    output sss_pkg::coord_t        center_y,
    output logic [15:0]            scan_pos,
    output logic [15:0]            score,
    output logic                   kept,
    output logic                   degenerate,
    output logic                   last_of_scan,
    output logic                   out_valid,
    input  logic                   out_ready
);
    import sss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CENTER, S_SCAN, S_MUL1, S_MUL2, S_NORM,
        S_Q1, S_Q2, S_SQRT, S_DIV, S_OUT
    } state_t;

    state_t              state_reg;
    job_t                job_reg;
    logic [WIN_BITS-1:0] j_reg;
    logic [WIN_BITS-1:0] hi_reg;
    coord_t              cx_reg, cy_reg;
    logic [5:0]          acc_reg;
    logic signed [21:0]  sx_reg, sy_reg;
    logic signed [40:0]  sxx_reg, syy_reg, sxy_reg;
    logic signed [63:0]  a_reg, c_reg, b_reg;
    logic signed [63:0]  p1_reg, p2_reg, p3_reg;
    logic [63:0]         ua_reg, uc_reg, ub_reg;
    logic [63:0]         q1_reg, q2_reg;
    logic [31:0]         t_reg;
    logic                keep_reg, degen_reg;
    logic [15:0]         score_reg;

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        ax, ay;
    logic [34:0]                dist2;
    logic [31:0]                lim2;
    logic                       gate;

    logic        sq_start, sq_done, dv_start, dv_done;
    logic [31:0] sq_root;
    logic [15:0] dv_quot;
    logic [31:0] d_clip;

    assign rd_slot = (state_reg == S_CENTER) ? job_reg.slot : j_reg[SLOT_BITS-1:0];
    assign dx      = (COORD_BITS+1)'(rd_x) - (COORD_BITS+1)'(cx_reg);
    assign dy      = (COORD_BITS+1)'(rd_y) - (COORD_BITS+1)'(cy_reg);
    assign ax      = dx[COORD_BITS] ? -dx : dx;
    assign ay      = dy[COORD_BITS] ? -dy : dy;
    assign dist2   = 35'(ax * ax) + 35'(ay * ay);
    assign lim2    = distance_limit * distance_limit;
    assign gate    = (ax <= 17'(distance_limit)) && (ay <= 17'(distance_limit))
                     && (dist2 <= 35'(lim2)) && (j_reg[SLOT_BITS-1:0] != job_reg.slot);

    assign job_take = (state_reg == S_IDLE) && job_valid;
    assign status.busy = state_reg != S_IDLE;
    assign out_valid   = state_reg == S_OUT;
    assign sq_start    = state_reg == S_Q2;
    assign d_clip      = (sq_root > t_reg) ? t_reg : sq_root;

    assign center_x     = cx_reg;
    assign center_y     = cy_reg;
    assign scan_pos     = job_reg.index;
    assign score        = score_reg;
    assign kept         = keep_reg;
    assign degenerate   = degen_reg;
    assign last_of_scan = job_reg.last;

    sss_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (q1_reg + q2_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    sss_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (t_reg - d_clip),
        .den   (t_reg + d_clip),
        .done  (dv_done),
        .quot  (dv_quot)
    );

    assign dv_start = (state_reg == S_SQRT) && sq_done;

    // scoring sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        state_reg <= S_CENTER;
                    end
                end
                S_CENTER:
                begin
                    // window bounds for this center
                    logic [WIN_BITS-1:0] lo;
                    lo = (job_reg.slot >= SLOT_BITS'(SIDE_SPAN))
                         ? WIN_BITS'(job_reg.slot) - WIN_BITS'(SIDE_SPAN) : '0;
                    if (lo < WIN_BITS'(WIN) - job_reg.fill)
                        lo = WIN_BITS'(WIN) - job_reg.fill;
                    j_reg  <= lo;
                    hi_reg <= (WIN_BITS'(job_reg.slot) + WIN_BITS'(SIDE_SPAN)
                               > WIN_BITS'(WIN - 1)) ? WIN_BITS'(WIN - 1)
                              : WIN_BITS'(job_reg.slot) + WIN_BITS'(SIDE_SPAN);
                    cx_reg  <= rd_x;
                    cy_reg  <= rd_y;
                    acc_reg <= '0;
                    sx_reg  <= '0;
                    sy_reg  <= '0;
                    sxx_reg <= '0;
                    syy_reg <= '0;
                    sxy_reg <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    // one neighbor per cycle
                    if (gate)
                    begin
                        acc_reg <= acc_reg + 6'd1;
                        sx_reg  <= sx_reg + 22'(dx);
                        sy_reg  <= sy_reg + 22'(dy);
                        sxx_reg <= sxx_reg + 41'(dx * dx);
                        syy_reg <= syy_reg + 41'(dy * dy);
                        sxy_reg <= sxy_reg + 41'(dx * dy);
                    end
                    j_reg <= j_reg + 1'b1;
                    if (j_reg == hi_reg)
                        state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    keep_reg  <= acc_reg >= min_neighbors;
                    degen_reg <= 1'b0;
                    score_reg <= '0;
                    p1_reg <= 64'(sxx_reg) * 64'(signed'({1'b0, acc_reg + 6'd1}));
                    p2_reg <= 64'(syy_reg) * 64'(signed'({1'b0, acc_reg + 6'd1}));
                    p3_reg <= 64'(sxy_reg) * 64'(signed'({1'b0, acc_reg + 6'd1}));
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    a_reg <= p1_reg - 64'(sx_reg) * 64'(sx_reg);
                    c_reg <= p2_reg - 64'(sy_reg) * 64'(sy_reg);
                    b_reg <= p3_reg - 64'(sx_reg) * 64'(sy_reg);
                    state_reg <= keep_reg ? S_NORM : S_OUT;
                end
                S_NORM:
                begin
                    logic [63:0] ua, uc, ub, m;
                    ua = a_reg[63] ? '0 : a_reg;
                    uc = c_reg[63] ? '0 : c_reg;
                    ub = b_reg[63] ? -b_reg : b_reg;
                    if (ua + uc == '0)
                    begin
                        degen_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        m = (ua > uc) ? ua : uc;
                        for (int s = 0; s < 8; s++)
                        begin
                            if (m >= 64'h4000_0000)
                            begin
                                m  = m >> 1;
                                ua = ua >> 1;
                                uc = uc >> 1;
                                ub = ub >> 1;
                            end
                        end
                        ua_reg <= ua;
                        uc_reg <= uc;
                        ub_reg <= ub;
                        // stay until magnitude fits
                        state_reg <= (m >= 64'h4000_0000) ? S_NORM : S_Q1;
                        a_reg <= ua;
                        c_reg <= uc;
                        b_reg <= ub;
                    end
                end
                S_Q1:
                begin
                    logic [63:0] ub, diff;
                    ub   = (ub_reg >= 64'h4000_0000) ? 64'h3FFF_FFFF : ub_reg;
                    diff = (ua_reg > uc_reg) ? ua_reg - uc_reg : uc_reg - ua_reg;
                    q1_reg <= 64'(diff[29:0] * diff[29:0]);
                    q2_reg <= 64'(ub[29:0] * ub[29:0]) << 2;
                    t_reg  <= 32'(ua_reg + uc_reg);
                    state_reg <= S_Q2;
                end
                S_Q2:
                begin
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sq_done)
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (dv_done)
                    begin
                        score_reg <= dv_quot;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== src/scan_smoothness_scorer.sv =====
// ----------------------------------------------------------------------------
// scan_smoothness_scorer
// Scores the local smoothness of ordered 2D scan points.
// ----------------------------------------------------------------------------
// Points enter on a valid/ready channel, one beat per point. Each point
// becomes a center and is scored once the point five places after it has
// arrived; an end_of_scan beat flushes all pending centers (up to six results)
// and clears the window. Results leave on a valid/ready channel.
// A kept center passes through job pickup, center fetch, the neighbor
// sweep, the scatter products, normalization, the squared terms, the
// bit-serial square root and the restoring divider. An unkept center goes
// straight to the output after the scatter products, a degenerate one
// after normalization. A point is taken only in the cycle after the last
// result of the previous point has left, so points are not overlapped and
// a flush costs up to six scorings; the sqrt and divider units set the rate.
// If the receiver stalls, the result holds on the outputs and no new point
// is taken. Reset empties the window and job queue and restores
// distance_limit = 65535 and min_neighbors = 0.
// ----------------------------------------------------------------------------
module scan_smoothness_scorer
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_data,
    input  sss_pkg::coord_t        pos_x,
    input  sss_pkg::coord_t        pos_y,
    input  logic                   end_of_scan,
    input  logic                   in_valid,
    output logic                   in_ready,
    output sss_pkg::coord_t        center_x,
    output sss_pkg::coord_t        center_y,
    output logic [15:0]            scan_pos,
    output logic [15:0]            score,
    output logic                   kept,
    output logic                   degenerate,
    output logic                   last_of_scan,
    output logic                   out_valid,
    input  logic                   out_ready
);
    import sss_pkg::*;

    logic [15:0]          distance_limit_reg;
    logic [5:0]           min_neighbors_reg;
    logic [SLOT_BITS-1:0] rd_slot;
    coord_t               rd_x, rd_y;
    logic                 job_valid, job_take;
    job_t                 job;
    back_status_t         status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_limit_reg <= 16'hFFFF;
            min_neighbors_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DISTANCE_LIMIT: distance_limit_reg <= cfg_data;
                CFG_MIN_NEIGHBORS:  min_neighbors_reg  <= cfg_data[5:0];
                default:            ;
            endcase
        end
    end

    sss_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .end_of_scan (end_of_scan),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rd_slot     (rd_slot),
        .rd_x        (rd_x),
        .rd_y        (rd_y),
        .job_valid   (job_valid),
        .job         (job),
        .job_take    (job_take),
        .status      (status)
    );

    sss_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .distance_limit (distance_limit_reg),
        .min_neighbors  (min_neighbors_reg),
        .job_valid      (job_valid),
        .job            (job),
        .job_take       (job_take),
        .rd_slot        (rd_slot),
        .rd_x           (rd_x),
        .rd_y           (rd_y),
        .status         (status),
        .center_x       (center_x),
        .center_y       (center_y),
        .scan_pos       (scan_pos),
        .score          (score),
        .kept           (kept),
        .degenerate     (degenerate),
        .last_of_scan   (last_of_scan),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

    // an unkept center never reports a score or degeneracy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kept |-> score == '0 && !degenerate)
        else $error("unkept result carries score");

    // degenerate results carry a zero score
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> score == '0)
        else $error("degenerate result with score");

    // no new point while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("point taken while result pending");

endmodule

// ===== tb/tb_scan_smoothness_scorer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scan_smoothness_scorer
// Self-checking bench for the scan smoothness scorer: a directed table of
// points, then random scans under several register settings and one longer
// scan sent back to back. An internal predictor scores every untyped center;
// each result beat is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_scan_smoothness_scorer;

    import sss_pkg::*;

    localparam int  MAX_CYCLES = 2_000_000;
    localparam int  SETTLE     = 150;
    localparam int  FULL_LEN   = 20;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] idx;
        logic [15:0] score;
        logic        kept;
        logic        degen;
        logic        last;
    } score_t;

    typedef struct {
        coord_t x;
        coord_t y;
        bit     eos;
        bit     typed;
        score_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    coord_t      pos_x;
    coord_t      pos_y;
    logic        end_of_scan;
    logic        in_valid;
    logic        in_ready;
    coord_t      center_x;
    coord_t      center_y;
    logic [15:0] scan_pos;
    logic [15:0] score;
    logic        kept;
    logic        degenerate;
    logic        last_of_scan;
    logic        out_valid;
    logic        out_ready;

    scan_smoothness_scorer dut (.*);

    // predictor state
    longint      win_x [WIN];
    longint      win_y [WIN];
    int          win_fill;
    bit [15:0]   scan_idx;
    bit [15:0]   dist_lim;
    bit [5:0]    min_nbrs;
    score_t      pending_scores[$];

    int          errors;
    int          n_points;
    int          n_scores;
    int          n_kept;
    int          n_degen;
    longint      cycles;
    bit          no_idle;
    int          burst_left;
    int          stall_left;

    // directed table: typed rows are single-point scans under reset settings
    row_t dir_rows [18] = '{
        '{16'sd0,      16'sd0,      1'b1, 1'b1, '{16'h0000, 16'h0000, 16'd0, 16'd0, 1, 1, 1}},
        '{16'sd32767, -16'sd32768,  1'b1, 1'b1, '{16'h7fff, 16'h8000, 16'd0, 16'd0, 1, 1, 1}},
        '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, '0},
        '{16'sd32767,  16'sd32767,  1'b0, 1'b0, '0},
        '{16'sd32767, -16'sd32768,  1'b0, 1'b0, '0},
        '{-16'sd32768, 16'sd32767,  1'b0, 1'b0, '0},
        '{16'sd0,      16'sd0,      1'b0, 1'b0, '0},
        '{16'sd1,     -16'sd1,      1'b1, 1'b0, '0},
        // round neighborhood around a center at the origin
        '{16'sd256,    16'sd0,      1'b0, 1'b0, '0},
        '{16'sd0,      16'sd256,    1'b0, 1'b0, '0},
        '{-16'sd256,   16'sd0,      1'b0, 1'b0, '0},
        '{16'sd0,     -16'sd256,    1'b0, 1'b0, '0},
        '{16'sd0,      16'sd0,      1'b0, 1'b0, '0},
        '{16'sd256,    16'sd0,      1'b0, 1'b0, '0},
        '{16'sd0,      16'sd256,    1'b0, 1'b0, '0},
        '{-16'sd256,   16'sd0,      1'b0, 1'b0, '0},
        '{16'sd0,     -16'sd256,    1'b0, 1'b0, '0},
        '{16'sd0,      16'sd0,      1'b1, 1'b0, '0}
    };

    // clock and cycle limit
    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("%0t timeout with %0d scores outstanding", $time,
                     pending_scores.size());
            $display("tb_scan_smoothness_scorer: errors");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // score the center held in window slot p
    function automatic score_t score_slot(int p, bit last);
        score_t          s;
        int              lo;
        int              hi;
        int              cnt;
        longint          dx;
        longint          dy;
        longint          sx;
        longint          sy;
        longint          sxx;
        longint          syy;
        longint          sxy;
        longint          n;
        longint          a;
        longint          c;
        longint          b;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned lim;
        longint unsigned ua;
        longint unsigned uc;
        longint unsigned ub;
        longint unsigned m;
        longint unsigned t;
        longint unsigned d;
        longint unsigned q;
        longint unsigned diff;
        s   = '0;
        lo  = (p >= SIDE_SPAN) ? p - SIDE_SPAN : 0;
        hi  = p + SIDE_SPAN;
        cnt = 0;
        sx  = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        lim = dist_lim;
        if (lo < WIN - win_fill)
            lo = WIN - win_fill;
        if (hi > WIN - 1)
            hi = WIN - 1;
        for (int j = lo; j <= hi; j++)
        begin
            if (j == p)
                continue;
            dx = win_x[j] - win_x[p];
            dy = win_y[j] - win_y[p];
            ax = magnitude(dx);
            ay = magnitude(dy);
            if (ax > lim || ay > lim || ax * ax + ay * ay > lim * lim)
                continue;
            cnt++;
            sx  += dx;
            sy  += dy;
            sxx += dx * dx;
            syy += dy * dy;
            sxy += dx * dy;
        end
        s.kept = (cnt >= min_nbrs);
        if (s.kept)
        begin
            n  = cnt + 1;
            a  = n * sxx - sx * sx;
            c  = n * syy - sy * sy;
            b  = n * sxy - sx * sy;
            ua = (a < 0) ? 0 : a;
            uc = (c < 0) ? 0 : c;
            ub = magnitude(b);
            if (ua + uc == 0)
                s.degen = 1'b1;
            else
            begin
                m = (ua > uc) ? ua : uc;
                while (m >= (64'd1 << 30))
                begin
                    m  >>= 1;
                    ua >>= 1;
                    uc >>= 1;
                    ub >>= 1;
                end
                if (ub >= (64'd1 << 30))
                    ub = (64'd1 << 30) - 1;
                diff = (ua > uc) ? ua - uc : uc - ua;
                q    = diff * diff + 4 * ub * ub;
                d    = int_sqrt(q);
                t    = ua + uc;
                if (d > t)
                    d = t;
                q = ((t - d) << 16) / (t + d);
                s.score = (q > 65535) ? 16'hffff : q[15:0];
            end
        end
        s.cx   = win_x[p][15:0];
        s.cy   = win_y[p][15:0];
        s.idx  = 16'(int'(scan_idx) + 32'h20000 - 1 - (WIN - 1 - p));
        s.last = last;
        return s;
    endfunction

    // append one expected result
    task automatic expect_score(score_t s);
        pending_scores.insert(pending_scores.size(), s);
    endtask

    // advance the predictor by one accepted point
    task automatic predict_point(coord_t x, coord_t y, bit eos, bit typed, score_t want);
        int first;
        for (int i = 0; i + 1 < WIN; i++)
        begin
            win_x[i] = win_x[i + 1];
            win_y[i] = win_y[i + 1];
        end
        win_x[WIN - 1] = longint'(x);
        win_y[WIN - 1] = longint'(y);
        if (win_fill < WIN)
            win_fill++;
        scan_idx++;
        n_points++;
        if (typed)
            expect_score(want);
        else if (!eos)
        begin
            if (win_fill >= SIDE_SPAN + 1)
                expect_score(score_slot(WIN - 1 - SIDE_SPAN, 1'b0));
        end
        else
        begin
            first = WIN - 1 - SIDE_SPAN;
            if (first < WIN - win_fill)
                first = WIN - win_fill;
            for (int i = first; i < WIN; i++)
                expect_score(score_slot(i, i == WIN - 1));
        end
        if (eos)
        begin
            win_fill = 0;
            scan_idx = 0;
        end
    endtask

    // one point beat: optional gap, then hold valid until accepted
    task automatic send_point(coord_t x, coord_t y, bit eos, bit typed, score_t want);
        int gap;
        gap = 0;
        if (!no_idle)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        pos_x       <= x;
        pos_y       <= y;
        end_of_scan <= eos;
        do
            @(posedge clk);
        while (!in_ready);
        predict_point(x, y, eos, typed, want);
    endtask

    task automatic write_reg(logic idx, bit [15:0] value);
        @(negedge clk);
        in_valid  <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_DISTANCE_LIMIT)
            dist_lim = value;
        else
            min_nbrs = value[5:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // pause the sender until every score is out and the back end is quiet
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // random scans: mostly smooth random walks, some wild points and repeats
    task automatic random_scans(int n_items);
        int     len;
        int     kind;
        longint px;
        longint py;
        int     sent;
        sent = 0;
        while (sent < n_items)
        begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24)
                                               : $urandom_range(1, 14);
            kind = $urandom_range(0, 9);
            px   = $signed(16'($urandom));
            py   = $signed(16'($urandom));
            for (int i = 0; i < len; i++)
            begin
                if (kind == 0)
                begin
                    px = $signed(16'($urandom));
                    py = $signed(16'($urandom));
                end
                else if (kind != 1 && $urandom_range(0, 5) != 0)
                begin
                    px += longint'($urandom_range(0, 1200)) - 600;
                    py += longint'($urandom_range(0, 1200)) - 600;
                end
                send_point(coord_t'(px), coord_t'(py), i == len - 1, 1'b0, '0);
            end
            sent += len;
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        score_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_scores.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result beat: expected none, actual index %h",
                         $time, scan_pos);
            end
            else
            begin
                want = pending_scores.pop_front();
                check_field("center_x", want.cx, center_x);
                check_field("center_y", want.cy, center_y);
                check_field("scan_pos", want.idx, scan_pos);
                check_field("score", want.score, score);
                check_field("kept", 16'(want.kept), 16'(kept));
                check_field("degenerate", 16'(want.degen), 16'(degenerate));
                check_field("last_of_scan", 16'(want.last), 16'(last_of_scan));
                n_scores++;
                n_kept  += want.kept;
                n_degen += want.degen;
            end
        end
    end

    // receiver stall pattern: runs of ready, short and long stalls
    always @(negedge clk)
    begin
        if (no_idle)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 15))
                0:       stall_left <= $urandom_range(5, 40);
                1, 2, 3: stall_left <= $urandom_range(0, 3);
                default: stall_left <= 0;
            endcase
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_DISTANCE_LIMIT;
        cfg_data    = '0;
        pos_x       = '0;
        pos_y       = '0;
        end_of_scan = 1'b0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        errors      = 0;
        n_points    = 0;
        n_scores    = 0;
        n_kept      = 0;
        n_degen     = 0;
        cycles      = 0;
        no_idle     = 1'b0;
        burst_left  = 0;
        stall_left  = 0;
        win_fill    = 0;
        scan_idx    = 0;
        dist_lim    = 16'hffff;
        min_nbrs    = 0;
        for (int i = 0; i < WIN; i++)
        begin
            win_x[i] = 0;
            win_y[i] = 0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed table under reset settings
        foreach (dir_rows[i])
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].eos,
                       dir_rows[i].typed, dir_rows[i].want);
        drain();

        // random scans under a sweep of register settings
        random_scans(30);
        drain();
        write_reg(CFG_DISTANCE_LIMIT, 16'h0000);
        write_reg(CFG_MIN_NEIGHBORS, 16'h0000);
        random_scans(25);
        drain();
        write_reg(CFG_DISTANCE_LIMIT, 16'd300);
        write_reg(CFG_MIN_NEIGHBORS, {10'($urandom), 6'd3});
        random_scans(30);
        drain();
        write_reg(CFG_DISTANCE_LIMIT, 16'd1200);
        write_reg(CFG_MIN_NEIGHBORS, 16'd10);
        random_scans(25);
        drain();
        write_reg(CFG_DISTANCE_LIMIT, 16'hffff);
        write_reg(CFG_MIN_NEIGHBORS, {10'($urandom), 6'd32});
        random_scans(20);
        drain();
        write_reg(CFG_DISTANCE_LIMIT, 16'($urandom));
        write_reg(CFG_MIN_NEIGHBORS, 16'($urandom_range(0, 11)));
        random_scans(30);
        drain();

        // one longer scan sent back to back with the receiver always ready
        write_reg(CFG_DISTANCE_LIMIT, 16'd2000);
        write_reg(CFG_MIN_NEIGHBORS, 16'd2);
        no_idle = 1'b1;
        for (int i = 0; i < FULL_LEN; i++)
            send_point(coord_t'($urandom_range(0, 1023)), coord_t'($urandom_range(0, 1023)),
                       i == FULL_LEN - 1, 1'b0, '0);
        no_idle = 1'b0;
        random_scans(10);
        drain();

        $display("covered %0d points and %0d scores (%0d kept, %0d degenerate)",
                 n_points, n_scores, n_kept, n_degen);
        $display("register sweep included zero and full distance limits, minimums 0 to 32");
        if (errors == 0)
            $display("tb_scan_smoothness_scorer: clean");
        else
            $display("tb_scan_smoothness_scorer: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sss_pkg.sv
src/sss_sqrt.sv
src/sss_div.sv
src/sss_front.sv
src/sss_back.sv
src/scan_smoothness_scorer.sv
tb/tb_scan_smoothness_scorer.sv
